// File: src/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// shared constants and helpers for the packed policy rule locator
// ----------------------------------------------------------------------------
package ppl_pkg;

    // width of reported bit positions
    localparam int POS_W      = 11;
    // width of one step of the shared position adder
    localparam int STEP_W     = 6;
    // width of the bit reader counters
    localparam int RD_CNT_W   = 3;
    // width of call and attribute countdowns
    localparam int LOOP_CNT_W = 4;

    // transaction modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RULE  = 2'd1;
    localparam logic [1:0] MODE_OBLIG = 2'd2;

    // attribute type codes
    localparam logic [2:0] ATTR_BOOL   = 3'd0;
    localparam logic [2:0] ATTR_BYTE   = 3'd1;
    localparam logic [2:0] ATTR_INT    = 3'd2;
    localparam logic [2:0] ATTR_FLOAT  = 3'd3;
    localparam logic [2:0] ATTR_STRING = 3'd4;
    localparam logic [2:0] ATTR_REQREF = 3'd5;
    localparam logic [2:0] ATTR_SYSREF = 3'd6;
    localparam logic [2:0] ATTR_LOCREF = 3'd7;

    // layout of the packed policy
    localparam int POLICY_HDR_POS = 8;   // policy effect, then has-rules
    localparam int POLICY_HDR_LEN = 2;
    localparam int RULE_HDR_OFF   = 8;   // rule effect, then five masks
    localparam int RULE_HDR_LEN   = 6;
    localparam int RULE_BODY_OFF  = 14;
    localparam int FIELD3_LEN     = 3;   // type codes, max indexes, action
    localparam int CALL_ID_LEN    = 8;

    // bits from the start of an attribute's type to its end, string excluded
    function automatic logic [STEP_W-1:0] attr_skip(input logic [2:0] kind);
        logic [STEP_W-1:0] w;
        case (kind)
            ATTR_BOOL:   w = STEP_W'(FIELD3_LEN + 1);
            ATTR_BYTE:   w = STEP_W'(FIELD3_LEN + 8);
            ATTR_INT:    w = STEP_W'(FIELD3_LEN + 16);
            ATTR_FLOAT:  w = STEP_W'(FIELD3_LEN + 32);
            ATTR_REQREF: w = STEP_W'(FIELD3_LEN + 8);
            ATTR_SYSREF: w = STEP_W'(FIELD3_LEN + 8);
            ATTR_LOCREF: w = STEP_W'(FIELD3_LEN + 3);
            default:     w = STEP_W'(FIELD3_LEN);
        endcase
        return w;
    endfunction

endpackage

// File: src/ppl_wrap_add.sv
// ----------------------------------------------------------------------------
// ppl_wrap_add
// shared position adder: adds a short step and wraps at the end of the store
// ----------------------------------------------------------------------------
module ppl_wrap_add #(
    parameter int TOTAL_BITS = 2048,
    localparam int PW = $clog2(TOTAL_BITS)
) (
    input  logic [PW-1:0]              a,
    input  logic [ppl_pkg::STEP_W-1:0] step,
    output logic [PW-1:0]              sum,
    output logic                       wrap
);
    import ppl_pkg::*;

    logic [PW:0] wide;
    logic [PW:0] wide_sub;

    // step is always shorter than the store, so one subtract is enough
    assign wide     = {1'b0, a} + (PW+1)'(step);
    assign wide_sub = wide - (PW+1)'(TOTAL_BITS);
    assign wrap     = (wide >= (PW+1)'(TOTAL_BITS));
    assign sum      = wrap ? wide_sub[PW-1:0] : wide[PW-1:0];

endmodule

// File: src/packed_policy_rule_locator_core.sv
// ----------------------------------------------------------------------------
// packed_policy_rule_locator_core
// bit-packed policy store with rule and obligation field locator
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start is high and busy is low.
//   mode write stores byte_value at byte_addr (modulo STORE_BYTES) in the
//   accepting cycle; busy stays low and no result follows. mode 3 is ignored.
//   rule and obligation queries raise busy and walk the store through a single
//   read port, one bit per cycle while a field is read, with every position
//   step done by one shared wrapping adder. the result is registered on the
//   output ports and held until the next rule or obligation query, marked by
//   done, which is high for one cycle; busy drops in that same cycle.
//   a rule query reads the policy and rule headers, then the action code if
//   present, then, with obligations, their count and every obligation call
//   with its attributes. an obligation query walks one call and then reads
//   its fulfill-on flag and, when that is set, its value.
//   the policy store itself has no reset; rst_n clears the sequencer and
//   the result registers. done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module packed_policy_rule_locator_core #(
    parameter int STORE_BYTES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic [7:0]                byte_addr,
    input  logic [7:0]                byte_value,
    input  logic [ppl_pkg::POS_W-1:0] bit_pos,
    output logic                      done,
    output logic                      policy_effect,
    output logic                      policy_has_rules,
    output logic                      rule_effect,
    output logic                      action_present,
    output logic [2:0]                action_code,
    output logic                      obligations_present,
    output logic [ppl_pkg::POS_W-1:0] first_expression_pos,
    output logic [ppl_pkg::POS_W-1:0] first_obligation_pos,
    output logic                      fulfill_present,
    output logic                      fulfill_value,
    output logic [ppl_pkg::POS_W-1:0] after_task_pos,
    output logic                      overrun
);
    import ppl_pkg::*;

    localparam int TOTAL_BITS = STORE_BYTES * 8;
    localparam int PW         = $clog2(TOTAL_BITS);
    localparam int AW         = $clog2(STORE_BYTES);
    localparam int EXT_W      = PW + POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_R_HDR,
        S_R_MASK,
        S_R_ACT,
        S_R_FE,
        S_R_OBN,
        S_C_ID,
        S_C_FLG,
        S_C_MAX,
        S_A_KIND,
        S_A_STR,
        S_R_END,
        S_O_HAS,
        S_O_CHK,
        S_O_VAL
    } state_t;

    // policy store and its read port
    logic [7:0]    mem [STORE_BYTES];
    logic [7:0]    rdata_reg;
    logic [2:0]    sel_reg;
    logic          bit_now;

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    logic [PW-1:0]         p_reg, p_next;
    logic [PW-1:0]         rp_reg, rp_next;
    logic [PW-1:0]         fe_reg, fe_next;
    logic [RD_CNT_W-1:0]   iss_left_reg, iss_left_next;
    logic [RD_CNT_W-1:0]   use_left_reg, use_left_next;
    logic                  pend_reg, pend_next;
    logic [7:0]            acc_reg, acc_next;
    logic [LOOP_CNT_W-1:0] calls_left_reg, calls_left_next;
    logic [LOOP_CNT_W-1:0] attrs_left_reg, attrs_left_next;
    logic                  is_rule_reg, is_rule_next;
    logic                  ovf_reg, ovf_next;
    logic                  done_reg, done_next;

    logic                  policy_effect_reg, policy_effect_next;
    logic                  policy_has_rules_reg, policy_has_rules_next;
    logic                  rule_effect_reg, rule_effect_next;
    logic                  action_present_reg, action_present_next;
    logic [2:0]            action_code_reg, action_code_next;
    logic                  obligations_present_reg, obligations_present_next;
    logic [POS_W-1:0]      first_expression_pos_reg, first_expression_pos_next;
    logic [POS_W-1:0]      first_obligation_pos_reg, first_obligation_pos_next;
    logic                  fulfill_present_reg, fulfill_present_next;
    logic                  fulfill_value_reg, fulfill_value_next;
    logic [POS_W-1:0]      after_task_pos_reg, after_task_pos_next;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_idx;
    logic [PW-1:0]         start_mod;

    logic [PW-1:0]         add_a;
    logic [STEP_W-1:0]     add_b;
    logic                  add_en;
    logic [PW-1:0]         add_sum;
    logic                  add_wrap;
    logic [EXT_W-1:0]      ext_sum;
    logic [EXT_W-1:0]      ext_p;
    logic [1:0]            mask_cnt;
    logic                  attr_done;
    logic                  call_done;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (mode == MODE_WRITE);

    // reduce the incoming byte address and bit position into the store
    always_comb
    begin
        logic [31:0] v;
        v = 32'(byte_addr);
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (32'(STORE_BYTES) << k))
                v = v - (32'(STORE_BYTES) << k);
        end
        wr_idx = v[AW-1:0];
    end

    always_comb
    begin
        logic [31:0] v;
        v = 32'(bit_pos);
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (32'(TOTAL_BITS) << k))
                v = v - (32'(TOTAL_BITS) << k);
        end
        start_mod = v[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= byte_value;
        rdata_reg <= mem[rp_reg[PW-1:3]];
        sel_reg   <= rp_reg[2:0];
    end

    // msb first within a byte
    assign bit_now = rdata_reg[3'd7 - sel_reg];

    ppl_wrap_add #(
        .TOTAL_BITS(TOTAL_BITS)
    ) u_add (
        .a    (add_a),
        .step (add_b),
        .sum  (add_sum),
        .wrap (add_wrap)
    );

    assign ext_sum  = EXT_W'(add_sum);
    assign ext_p    = EXT_W'(p_reg);
    assign mask_cnt = 2'(acc_reg[4]) + 2'(acc_reg[3]) + 2'(acc_reg[2]);

    always_comb
    begin
        state_next                = state_reg;
        ret_next                  = ret_reg;
        p_next                    = p_reg;
        rp_next                   = rp_reg;
        fe_next                   = fe_reg;
        iss_left_next             = iss_left_reg;
        use_left_next             = use_left_reg;
        pend_next                 = pend_reg;
        acc_next                  = acc_reg;
        calls_left_next           = calls_left_reg;
        attrs_left_next           = attrs_left_reg;
        is_rule_next              = is_rule_reg;
        ovf_next                  = ovf_reg;
        done_next                 = 1'b0;
        policy_effect_next        = policy_effect_reg;
        policy_has_rules_next     = policy_has_rules_reg;
        rule_effect_next          = rule_effect_reg;
        action_present_next       = action_present_reg;
        action_code_next          = action_code_reg;
        obligations_present_next  = obligations_present_reg;
        first_expression_pos_next = first_expression_pos_reg;
        first_obligation_pos_next = first_obligation_pos_reg;
        fulfill_present_next      = fulfill_present_reg;
        fulfill_value_next        = fulfill_value_reg;
        after_task_pos_next       = after_task_pos_reg;
        add_a                     = p_reg;
        add_b                     = '0;
        add_en                    = 1'b0;
        attr_done                 = 1'b0;
        call_done                 = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_RULE || mode == MODE_OBLIG))
                begin
                    policy_effect_next        = 1'b0;
                    policy_has_rules_next     = 1'b0;
                    rule_effect_next          = 1'b0;
                    action_present_next       = 1'b0;
                    action_code_next          = '0;
                    obligations_present_next  = 1'b0;
                    first_expression_pos_next = '0;
                    first_obligation_pos_next = '0;
                    fulfill_present_next      = 1'b0;
                    fulfill_value_next        = 1'b0;
                    after_task_pos_next       = '0;
                    ovf_next                  = 1'b0;
                    p_next                    = start_mod;
                    calls_left_next           = LOOP_CNT_W'(1);
                    is_rule_next              = (mode == MODE_RULE);
                    if (mode == MODE_RULE)
                    begin
                        rp_next       = PW'(POLICY_HDR_POS);
                        iss_left_next = RD_CNT_W'(POLICY_HDR_LEN);
                        use_left_next = RD_CNT_W'(POLICY_HDR_LEN);
                        pend_next     = 1'b0;
                        ret_next      = S_R_HDR;
                        state_next    = S_READ;
                    end
                    else
                    begin
                        state_next = S_C_ID;
                    end
                end
            end

            // bit reader: issues one address and takes one bit per cycle
            S_READ:
            begin
                if (pend_reg)
                begin
                    acc_next      = {acc_reg[6:0], bit_now};
                    use_left_next = use_left_reg - 1'b1;
                    if (use_left_reg == RD_CNT_W'(1))
                        state_next = ret_reg;
                end
                if (iss_left_reg != '0)
                begin
                    pend_next     = 1'b1;
                    iss_left_next = iss_left_reg - 1'b1;
                    if (iss_left_reg >= RD_CNT_W'(2))
                    begin
                        add_a   = rp_reg;
                        add_b   = STEP_W'(1);
                        add_en  = 1'b1;
                        rp_next = add_sum;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_R_HDR:
            begin
                policy_effect_next    = acc_reg[1];
                policy_has_rules_next = acc_reg[0];
                add_b         = STEP_W'(RULE_HDR_OFF);
                add_en        = 1'b1;
                rp_next       = add_sum;
                iss_left_next = RD_CNT_W'(RULE_HDR_LEN);
                use_left_next = RD_CNT_W'(RULE_HDR_LEN);
                pend_next     = 1'b0;
                ret_next      = S_R_MASK;
                state_next    = S_READ;
            end

            // effect, three byte-field masks, action mask, obligation mask
            S_R_MASK:
            begin
                rule_effect_next         = acc_reg[5];
                action_present_next      = acc_reg[1];
                obligations_present_next = acc_reg[0];
                add_b  = STEP_W'(RULE_BODY_OFF) + STEP_W'({mask_cnt, 3'b000});
                add_en = 1'b1;
                p_next = add_sum;
                if (acc_reg[1])
                begin
                    rp_next       = add_sum;
                    iss_left_next = RD_CNT_W'(FIELD3_LEN);
                    use_left_next = RD_CNT_W'(FIELD3_LEN);
                    pend_next     = 1'b0;
                    ret_next      = S_R_ACT;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_R_FE;
                end
            end

            S_R_ACT:
            begin
                action_code_next = acc_reg[2:0];
                add_b      = STEP_W'(FIELD3_LEN);
                add_en     = 1'b1;
                p_next     = add_sum;
                state_next = S_R_FE;
            end

            S_R_FE:
            begin
                add_b   = STEP_W'(FIELD3_LEN);
                add_en  = 1'b1;
                fe_next = add_sum;
                first_expression_pos_next = ext_sum[POS_W-1:0];
                if (obligations_present_reg)
                begin
                    rp_next       = p_reg;
                    iss_left_next = RD_CNT_W'(FIELD3_LEN);
                    use_left_next = RD_CNT_W'(FIELD3_LEN);
                    pend_next     = 1'b0;
                    ret_next      = S_R_OBN;
                    state_next    = S_READ;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_R_OBN:
            begin
                calls_left_next = LOOP_CNT_W'(acc_reg[2:0]) + 1'b1;
                p_next          = fe_reg;
                state_next      = S_C_ID;
            end

            // skip the call id, then read its attribute flag
            S_C_ID:
            begin
                add_b         = STEP_W'(CALL_ID_LEN);
                add_en        = 1'b1;
                p_next        = add_sum;
                rp_next       = add_sum;
                iss_left_next = RD_CNT_W'(1);
                use_left_next = RD_CNT_W'(1);
                pend_next     = 1'b0;
                ret_next      = S_C_FLG;
                state_next    = S_READ;
            end

            S_C_FLG:
            begin
                add_b  = STEP_W'(1);
                add_en = 1'b1;
                p_next = add_sum;
                if (acc_reg[0])
                begin
                    rp_next       = add_sum;
                    iss_left_next = RD_CNT_W'(FIELD3_LEN);
                    use_left_next = RD_CNT_W'(FIELD3_LEN);
                    pend_next     = 1'b0;
                    ret_next      = S_C_MAX;
                    state_next    = S_READ;
                end
                else
                begin
                    call_done = 1'b1;
                end
            end

            S_C_MAX:
            begin
                attrs_left_next = LOOP_CNT_W'(acc_reg[2:0]) + 1'b1;
                add_b         = STEP_W'(FIELD3_LEN);
                add_en        = 1'b1;
                p_next        = add_sum;
                rp_next       = add_sum;
                iss_left_next = RD_CNT_W'(FIELD3_LEN);
                use_left_next = RD_CNT_W'(FIELD3_LEN);
                pend_next     = 1'b0;
                ret_next      = S_A_KIND;
                state_next    = S_READ;
            end

            S_A_KIND:
            begin
                add_en = 1'b1;
                if (acc_reg[2:0] == ATTR_STRING)
                begin
                    add_b         = STEP_W'(FIELD3_LEN);
                    p_next        = add_sum;
                    rp_next       = add_sum;
                    iss_left_next = RD_CNT_W'(FIELD3_LEN);
                    use_left_next = RD_CNT_W'(FIELD3_LEN);
                    pend_next     = 1'b0;
                    ret_next      = S_A_STR;
                    state_next    = S_READ;
                end
                else
                begin
                    add_b     = attr_skip(acc_reg[2:0]);
                    p_next    = add_sum;
                    attr_done = 1'b1;
                end
            end

            // length field, then eight bits per character
            S_A_STR:
            begin
                add_b     = STEP_W'(FIELD3_LEN) + STEP_W'({acc_reg[2:0], 3'b000});
                add_en    = 1'b1;
                p_next    = add_sum;
                attr_done = 1'b1;
            end

            S_R_END:
            begin
                add_b  = STEP_W'(FIELD3_LEN);
                add_en = 1'b1;
                first_obligation_pos_next = ext_sum[POS_W-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_O_HAS:
            begin
                after_task_pos_next = ext_p[POS_W-1:0];
                rp_next       = p_reg;
                iss_left_next = RD_CNT_W'(1);
                use_left_next = RD_CNT_W'(1);
                pend_next     = 1'b0;
                ret_next      = S_O_CHK;
                state_next    = S_READ;
            end

            S_O_CHK:
            begin
                fulfill_present_next = acc_reg[0];
                if (acc_reg[0])
                begin
                    add_b         = STEP_W'(1);
                    add_en        = 1'b1;
                    rp_next       = add_sum;
                    iss_left_next = RD_CNT_W'(1);
                    use_left_next = RD_CNT_W'(1);
                    pend_next     = 1'b0;
                    ret_next      = S_O_VAL;
                    state_next    = S_READ;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_O_VAL:
            begin
                fulfill_value_next = acc_reg[0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next attribute type is read at the new position
        if (attr_done)
        begin
            if (attrs_left_reg == LOOP_CNT_W'(1))
            begin
                call_done = 1'b1;
            end
            else
            begin
                attrs_left_next = attrs_left_reg - 1'b1;
                rp_next         = add_sum;
                iss_left_next   = RD_CNT_W'(FIELD3_LEN);
                use_left_next   = RD_CNT_W'(FIELD3_LEN);
                pend_next       = 1'b0;
                ret_next        = S_A_KIND;
                state_next      = S_READ;
            end
        end

        if (call_done)
        begin
            if (calls_left_reg == LOOP_CNT_W'(1))
            begin
                state_next = is_rule_reg ? S_R_END : S_O_HAS;
            end
            else
            begin
                calls_left_next = calls_left_reg - 1'b1;
                state_next      = S_C_ID;
            end
        end

        // any step of the shared adder that wraps past the end of the store sets overrun
        if (add_en && add_wrap)
            ovf_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= S_IDLE;
            ret_reg                  <= S_IDLE;
            iss_left_reg             <= '0;
            use_left_reg             <= '0;
            pend_reg                 <= 1'b0;
            calls_left_reg           <= '0;
            attrs_left_reg           <= '0;
            is_rule_reg              <= 1'b0;
            ovf_reg                  <= 1'b0;
            done_reg                 <= 1'b0;
            policy_effect_reg        <= 1'b0;
            policy_has_rules_reg     <= 1'b0;
            rule_effect_reg          <= 1'b0;
            action_present_reg       <= 1'b0;
            action_code_reg          <= '0;
            obligations_present_reg  <= 1'b0;
            first_expression_pos_reg <= '0;
            first_obligation_pos_reg <= '0;
            fulfill_present_reg      <= 1'b0;
            fulfill_value_reg        <= 1'b0;
            after_task_pos_reg       <= '0;
        end
        else
        begin
            state_reg                <= state_next;
            ret_reg                  <= ret_next;
            iss_left_reg             <= iss_left_next;
            use_left_reg             <= use_left_next;
            pend_reg                 <= pend_next;
            calls_left_reg           <= calls_left_next;
            attrs_left_reg           <= attrs_left_next;
            is_rule_reg              <= is_rule_next;
            ovf_reg                  <= ovf_next;
            done_reg                 <= done_next;
            policy_effect_reg        <= policy_effect_next;
            policy_has_rules_reg     <= policy_has_rules_next;
            rule_effect_reg          <= rule_effect_next;
            action_present_reg       <= action_present_next;
            action_code_reg          <= action_code_next;
            obligations_present_reg  <= obligations_present_next;
            first_expression_pos_reg <= first_expression_pos_next;
            first_obligation_pos_reg <= first_obligation_pos_next;
            fulfill_present_reg      <= fulfill_present_next;
            fulfill_value_reg        <= fulfill_value_next;
            after_task_pos_reg       <= after_task_pos_next;
        end
    end

    // position and shift registers carry no reset
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        rp_reg  <= rp_next;
        fe_reg  <= fe_next;
        acc_reg <= acc_next;
    end

    assign done                 = done_reg;
    assign policy_effect        = policy_effect_reg;
    assign policy_has_rules     = policy_has_rules_reg;
    assign rule_effect          = rule_effect_reg;
    assign action_present       = action_present_reg;
    assign action_code          = action_code_reg;
    assign obligations_present  = obligations_present_reg;
    assign first_expression_pos = first_expression_pos_reg;
    assign first_obligation_pos = first_obligation_pos_reg;
    assign fulfill_present      = fulfill_present_reg;
    assign fulfill_value        = fulfill_value_reg;
    assign after_task_pos       = after_task_pos_reg;
    assign overrun              = ovf_reg;

endmodule
